// ----- rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros
// assertion macros shared by the rtl, each with an active and an empty form
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property that must hold in the same cycle as its trigger
`define MWA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// property that must hold whenever the design is out of reset
`define MWA_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

`else

`define MWA_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define MWA_ASSERT_ALWAYS(label, clk, rst, cond)

`endif

`endif

// ----- rtl/mwa_pkg.sv -----
// ---------------------------------------------------------------------------
// mwa_pkg
// shared constants and types of the moving window average block
// ---------------------------------------------------------------------------
package mwa_pkg;

   // default sizes
   localparam int MAX_WINDOW_DEF  = 64;
   localparam int SAMPLE_BITS_DEF = 16;

   // window length register
   localparam int               CFG_W            = 7;
   localparam logic [CFG_W-1:0] WINDOW_LEN_RESET = 7'd30;

   // entries of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // back end sequencer states
   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SUM,
      BK_DIV,
      BK_DONE
   } bk_state_type;

   // classification of one request
   typedef struct packed {
      logic restart;   // clear sum before this sample
      logic drop_old;  // window full, subtract the leaving sample
   } mwa_ctl_type;

endpackage

// ----- rtl/mwa_front.sv -----
// ---------------------------------------------------------------------------
// mwa_front
// accepts requests, tracks write position and fill count, works out the
// history slots, the divisor and the control flags of each request
// ---------------------------------------------------------------------------
module mwa_front #(
   parameter int MAX_WINDOW  = mwa_pkg::MAX_WINDOW_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [mwa_pkg::CFG_W-1:0]     window_len,
   input  logic                          req_valid,
   input  logic                          req_restart,
   input  logic                          q_full,
   output logic                          req_stall,
   output logic                          push,
   output logic [$clog2(MAX_WINDOW)-1:0] waddr,
   output logic [$clog2(MAX_WINDOW)-1:0] raddr,
   output logic [$clog2(MAX_WINDOW+1)-1:0] divisor,
   output mwa_pkg::mwa_ctl_type          ctl
);

   localparam int AW    = $clog2(MAX_WINDOW);
   localparam int CNT_W = $clog2(MAX_WINDOW + 1);
   localparam int CMP_W = (CNT_W > mwa_pkg::CFG_W) ? CNT_W : mwa_pkg::CFG_W;

   logic [AW-1:0]    wpos_ff, wpos_in;
   logic [CNT_W-1:0] seen_ff, seen_in;
   logic [CNT_W-1:0] win;
   logic [CNT_W-1:0] seen_base;
   logic [CNT_W:0]   wpos_ext;
   logic [CNT_W:0]   back_pos;
   logic [CMP_W-1:0] cfg_ext;

   // handshake
   assign req_stall = q_full;
   assign push      = req_valid & ~q_full;

   // effective window, zero taken as one, clipped at the history depth
   assign cfg_ext = CMP_W'(window_len);
   always_comb begin
      priority if (window_len == '0) begin
         win = CNT_W'(1);
      end else if (cfg_ext > CMP_W'(MAX_WINDOW)) begin
         win = CNT_W'(MAX_WINDOW);
      end else begin
         win = CNT_W'(cfg_ext);
      end
   end

   // fill count as seen by this request
   assign seen_base = req_restart ? '0 : seen_ff;

   always_comb begin
      if (seen_base < CNT_W'(MAX_WINDOW)) begin
         seen_in = seen_base + CNT_W'(1);
      end else begin
         seen_in = seen_base;
      end
   end

   // slot of the sample leaving the window
   assign wpos_ext = (CNT_W+1)'(wpos_ff);
   always_comb begin
      if (wpos_ext >= (CNT_W+1)'(win)) begin
         back_pos = wpos_ext - (CNT_W+1)'(win);
      end else begin
         back_pos = wpos_ext + (CNT_W+1)'(MAX_WINDOW) - (CNT_W+1)'(win);
      end
   end

   assign wpos_in = (wpos_ff == AW'(MAX_WINDOW - 1)) ? '0 : wpos_ff + AW'(1);

   // classified request
   assign waddr        = wpos_ff;
   assign raddr        = AW'(back_pos);
   assign divisor      = (seen_in < win) ? seen_in : win;
   assign ctl.restart  = req_restart;
   assign ctl.drop_old = (seen_base >= win);

   // position and count registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wpos_ff <= '0;
         seen_ff <= '0;
      end else if (push) begin
         wpos_ff <= wpos_in;
         seen_ff <= seen_in;
      end
   end

endmodule

// ----- rtl/mwa_queue.sv -----
// ---------------------------------------------------------------------------
// mwa_queue
// short fifo between the front and the back end
// ---------------------------------------------------------------------------
module mwa_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             full,
   output logic             not_empty,
   output logic [WIDTH-1:0] head,
   output logic [$clog2(mwa_pkg::QUEUE_DEPTH+1)-1:0] count
);

   localparam int DEPTH = mwa_pkg::QUEUE_DEPTH;
   localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ff, wr_in;
   logic [PW-1:0]    rd_ff, rd_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full      = (cnt_ff == CW'(DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign head      = slot_ff[rd_ff];
   assign count     = cnt_ff;

   assign do_push = push & ~full;
   assign do_pop  = pop & not_empty;

   // pointer and count update
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/mwa_back.sv -----
// ---------------------------------------------------------------------------
// mwa_back
// history memory, running sum, bit-serial divider and result register
// ---------------------------------------------------------------------------
module mwa_back #(
   parameter int MAX_WINDOW  = mwa_pkg::MAX_WINDOW_DEF,
   parameter int SAMPLE_BITS = mwa_pkg::SAMPLE_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            q_valid,
   input  logic [SAMPLE_BITS-1:0]          q_sample,
   input  logic [$clog2(MAX_WINDOW)-1:0]   q_waddr,
   input  logic [$clog2(MAX_WINDOW)-1:0]   q_raddr,
   input  logic [$clog2(MAX_WINDOW+1)-1:0] q_divisor,
   input  mwa_pkg::mwa_ctl_type            q_ctl,
   output logic                            q_pop,
   input  logic                            rsp_stall,
   output logic                            rsp_valid,
   output logic signed [SAMPLE_BITS-1:0]   rsp_average
);

   localparam int DIV_W = $clog2(MAX_WINDOW + 1);
   localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_WINDOW) + 1;
   localparam int DC_W  = $clog2(SUM_W);
   localparam int S     = SAMPLE_BITS;

   mwa_pkg::bk_state_type state_ff, state_in;

   logic [S-1:0]     hist_mem [MAX_WINDOW];
   logic [S-1:0]     old_ff;
   logic [S-1:0]     smp_ff;
   mwa_pkg::mwa_ctl_type ctl_ff;
   logic [DIV_W-1:0] div_ff;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [SUM_W-1:0] quo_ff;
   logic [DIV_W-1:0] rem_ff;
   logic [DC_W-1:0]  cnt_ff;
   logic             neg_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [S-1:0]     rsp_avg_ff, rsp_avg_in;

   logic             load_out;
   logic             div_last;
   logic [DIV_W:0]   rem_shift;
   logic             q_bit;
   logic [SUM_W-1:0] mag_in;
   logic [SUM_W-1:0] sub_val;
   logic [SUM_W-1:0] base_sum;

   // sequencer
   always_comb begin
      state_in = state_ff;
      q_pop    = 1'b0;
      load_out = 1'b0;
      unique case (state_ff)
         mwa_pkg::BK_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               state_in = mwa_pkg::BK_SUM;
            end
         end
         mwa_pkg::BK_SUM: begin
            state_in = mwa_pkg::BK_DIV;
         end
         mwa_pkg::BK_DIV: begin
            if (div_last) begin
               state_in = mwa_pkg::BK_DONE;
            end
         end
         mwa_pkg::BK_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load_out = 1'b1;
               state_in = mwa_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = mwa_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mwa_pkg::BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // history: old entry read in the same cycle as the new one is written
   always_ff @(posedge clock) begin
      if (q_pop) begin
         hist_mem[q_waddr] <= q_sample;
      end
      old_ff <= hist_mem[q_raddr];
   end

   // request held for the back end
   always_ff @(posedge clock) begin
      if (q_pop) begin
         smp_ff <= q_sample;
         ctl_ff <= q_ctl;
         div_ff <= q_divisor;
      end
   end

   // running sum, wraps in its own width
   assign base_sum = ctl_ff.restart ? '0 : sum_ff;
   assign sub_val  = ctl_ff.drop_old ? {{(SUM_W-S){old_ff[S-1]}}, old_ff} : '0;
   assign sum_in   = base_sum + {{(SUM_W-S){smp_ff[S-1]}}, smp_ff} - sub_val;
   assign mag_in   = sum_in[SUM_W-1] ? (~sum_in + SUM_W'(1)) : sum_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else if (state_ff == mwa_pkg::BK_SUM) begin
         sum_ff <= sum_in;
      end
   end

   // restoring divider step
   assign rem_shift = {rem_ff, quo_ff[SUM_W-1]};
   assign q_bit     = (rem_shift >= {1'b0, div_ff});
   assign div_last  = (cnt_ff == DC_W'(SUM_W - 1));

   always_ff @(posedge clock) begin
      if (state_ff == mwa_pkg::BK_SUM) begin
         quo_ff <= mag_in;
         neg_ff <= sum_in[SUM_W-1];
         rem_ff <= '0;
         cnt_ff <= '0;
      end else if (state_ff == mwa_pkg::BK_DIV) begin
         quo_ff <= {quo_ff[SUM_W-2:0], q_bit};
         rem_ff <= q_bit ? DIV_W'(rem_shift - {1'b0, div_ff}) : rem_shift[DIV_W-1:0];
         cnt_ff <= cnt_ff + DC_W'(1);
      end
   end

   // sign and saturation of the quotient
   always_comb begin
      priority if (!neg_ff && (quo_ff > SUM_W'((1 << (S-1)) - 1))) begin
         rsp_avg_in = {1'b0, {(S-1){1'b1}}};
      end else if (neg_ff && (quo_ff > SUM_W'(1 << (S-1)))) begin
         rsp_avg_in = {1'b1, {(S-1){1'b0}}};
      end else if (neg_ff) begin
         rsp_avg_in = ~quo_ff[S-1:0] + S'(1);
      end else begin
         rsp_avg_in = quo_ff[S-1:0];
      end
   end

   // result register
   assign rsp_valid_in = load_out | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_avg_ff <= rsp_avg_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_average = rsp_avg_ff;

endmodule

// ----- rtl/moving_window_average_top.sv -----
// a request waits in the queue, then the back end passes through its sum, divide
//   and done states before the result register is loaded
// the bit-serial divider back end takes a new request only once the last result is loaded
// a two-entry queue takes requests while the back end is busy
// reset (synchronous, active high) clears sum, count, write position and
//   queue and sets the window length to 30; the history is not cleared
// ---------------------------------------------------------------------------
// moving_window_average_top
// streaming moving window average with a programmable window length
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module moving_window_average_top #(
   parameter int MAX_WINDOW  = mwa_pkg::MAX_WINDOW_DEF,
   parameter int SAMPLE_BITS = mwa_pkg::SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic                          req_restart,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_average,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [mwa_pkg::CFG_W-1:0]     csr_data
);

   localparam int AW    = $clog2(MAX_WINDOW);
   localparam int DIV_W = $clog2(MAX_WINDOW + 1);
   localparam int CTL_W = $bits(mwa_pkg::mwa_ctl_type);
   localparam int QW    = SAMPLE_BITS + 2 * AW + DIV_W + CTL_W;
   localparam int QC_W  = $clog2(mwa_pkg::QUEUE_DEPTH + 1);

   logic [mwa_pkg::CFG_W-1:0] win_len_ff;
   logic                      push;
   logic                      q_full, q_valid, q_pop;
   logic [QC_W-1:0]           q_count;
   logic [AW-1:0]             f_waddr, f_raddr, b_waddr, b_raddr;
   logic [DIV_W-1:0]          f_div, b_div;
   mwa_pkg::mwa_ctl_type      f_ctl, b_ctl;
   logic [SAMPLE_BITS-1:0]    b_sample;
   logic [QW-1:0]             q_in, q_head;

   // window length register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_len_ff <= mwa_pkg::WINDOW_LEN_RESET;
      end else if (csr_valid && csr_ready) begin
         win_len_ff <= csr_data;
      end
   end

   // front: accept and classify
   mwa_front #(
      .MAX_WINDOW  (MAX_WINDOW)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .window_len  (win_len_ff),
      .req_valid   (req_valid),
      .req_restart (req_restart),
      .q_full      (q_full),
      .req_stall   (req_stall),
      .push        (push),
      .waddr       (f_waddr),
      .raddr       (f_raddr),
      .divisor     (f_div),
      .ctl         (f_ctl)
   );

   // queue between front and back
   assign q_in = {req_sample, f_waddr, f_raddr, f_div, f_ctl};

   mwa_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (q_in),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_valid),
      .head      (q_head),
      .count     (q_count)
   );

   assign {b_sample, b_waddr, b_raddr, b_div, b_ctl} = q_head;

   // back: sum, divide, result
   mwa_back #(
      .MAX_WINDOW  (MAX_WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_sample    (b_sample),
      .q_waddr     (b_waddr),
      .q_raddr     (b_raddr),
      .q_divisor   (b_div),
      .q_ctl       (b_ctl),
      .q_pop       (q_pop),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_average (rsp_average)
   );

   // checks
   `MWA_ASSERT_ALWAYS(a_queue_bound, clock, reset, q_count <= QC_W'(mwa_pkg::QUEUE_DEPTH))
   `MWA_ASSERT_IMPLY(a_push_room, clock, reset, req_valid && !req_stall, !q_full)
   `MWA_ASSERT_IMPLY(a_div_nonzero, clock, reset, q_valid, b_div != '0)

endmodule

// ----- test/moving_window_average_checker.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// moving_window_average_checker
// watches the request, result and window length channels of the moving
// window average block, predicts each average from its own copy of the
// window state and compares the results in order
// ---------------------------------------------------------------------------
module moving_window_average_checker #(
   parameter int MAX_WINDOW  = mwa_pkg::MAX_WINDOW_DEF,
   parameter int SAMPLE_BITS = mwa_pkg::SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic                          req_restart,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic signed [SAMPLE_BITS-1:0] rsp_average,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [mwa_pkg::CFG_W-1:0]     csr_data,
   output int                            pending_count,
   output int                            error_count
);

   localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_WINDOW) + 1;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   // predicted window state
   logic [mwa_pkg::CFG_W-1:0] window_reg;
   sample_type        hist [MAX_WINDOW];
   int                wr_pos;
   int                seen_cnt;
   logic signed [SUM_W-1:0] run_sum;

   // averages waiting for their result
   sample_type        avg_queue [$];
   int                results_seen;

   initial begin
      pending_count = 0;
      error_count   = 0;
      results_seen  = 0;
   end

   // take in one sample and return the average it produces
   function automatic sample_type advance_average(input sample_type smp, input logic rst_rec);
      int     win;
      int     divisor;
      longint quot;
      longint hi_lim;
      longint lo_lim;
      win = int'(window_reg);
      if (win == 0) win = 1;
      if (win > MAX_WINDOW) win = MAX_WINDOW;
      if (rst_rec) begin
         run_sum  = '0;
         seen_cnt = 0;
      end
      // add the new sample, drop the one leaving the window
      run_sum = run_sum + smp;
      if (seen_cnt >= win) begin
         run_sum = run_sum - hist[(wr_pos + MAX_WINDOW - win) % MAX_WINDOW];
      end
      hist[wr_pos] = smp;
      wr_pos = (wr_pos + 1) % MAX_WINDOW;
      if (seen_cnt < MAX_WINDOW) seen_cnt++;
      // divide with truncation toward zero, then clamp to the sample range
      divisor = (seen_cnt < win) ? seen_cnt : win;
      quot    = longint'(run_sum) / divisor;
      hi_lim  = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
      lo_lim  = -hi_lim - 1;
      if (quot > hi_lim) quot = hi_lim;
      if (quot < lo_lim) quot = lo_lim;
      return sample_type'(quot);
   endfunction

   // follow the channels and compare
   always @(posedge clock) begin
      sample_type want;
      if (reset) begin
         window_reg = mwa_pkg::WINDOW_LEN_RESET;
         wr_pos     = 0;
         seen_cnt   = 0;
         run_sum    = '0;
         avg_queue.delete();
         pending_count <= 0;
      end else begin
         if (csr_valid && csr_ready) window_reg = csr_data;
         if (req_valid && !req_stall) begin
            avg_queue.push_back(advance_average(req_sample, req_restart));
         end
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (avg_queue.size() == 0) begin
               if (error_count < 10) begin
                  $display("result %0d: unexpected, average %0d", results_seen, rsp_average);
               end
               error_count <= error_count + 1;
            end else begin
               want = avg_queue.pop_front();
               if (rsp_average !== want) begin
                  if (error_count < 10) begin
                     $display("result %0d: expected average %0d, got %0d",
                              results_seen, want, rsp_average);
                  end
                  error_count <= error_count + 1;
               end
            end
         end
         pending_count <= avg_queue.size();
      end
   end

endmodule

// ----- test/moving_window_average_top_tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// moving_window_average_top_tb
// drives samples and window lengths into the moving window average block
// with random gaps and stalls; a checker beside the block predicts and
// compares every average
// ---------------------------------------------------------------------------
module moving_window_average_top_tb;

   localparam int SAMPLE_BITS   = mwa_pkg::SAMPLE_BITS_DEF;
   localparam int MAX_WINDOW    = mwa_pkg::MAX_WINDOW_DEF;
   localparam int CFG_W         = mwa_pkg::CFG_W;
   localparam int SETTLE_CYCLES = SAMPLE_BITS + $clog2(MAX_WINDOW) + 8;
   localparam int RANDOM_ITEMS  = 650;
   localparam int LONG_HOLD     = 400;
   localparam int CYCLE_LIMIT   = 600000;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic [CFG_W-1:0]              window_type;

   localparam sample_type SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam sample_type SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam window_type WIN_TOP = {CFG_W{1'b1}};

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_valid   = 1'b0;
   logic             req_stall;
   sample_type       req_sample  = '0;
   logic             req_restart = 1'b0;
   logic             rsp_valid;
   logic             rsp_stall   = 1'b1;
   sample_type       rsp_average;
   logic             csr_valid   = 1'b0;
   logic             csr_ready;
   window_type       csr_data    = '0;

   logic             hold_go     = 1'b0;
   int               pending_count;
   int               error_count;
   int               requests_sent = 0;
   int               cycle_count   = 0;

   moving_window_average_top #(
      .MAX_WINDOW  (MAX_WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_sample  (req_sample),
      .req_restart (req_restart),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_average (rsp_average),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   moving_window_average_checker #(
      .MAX_WINDOW  (MAX_WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_sample    (req_sample),
      .req_restart   (req_restart),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_average   (rsp_average),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data),
      .pending_count (pending_count),
      .error_count   (error_count)
   );

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // sender gap, mostly short with a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // sample value biased toward the extremes and small numbers
   function automatic sample_type pick_sample();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return SMP_MAX;
      if (r == 1) return SMP_MIN;
      if (r == 2) return sample_type'(int'($urandom_range(0, 16)) - 8);
      return sample_type'($urandom());
   endfunction

   // window length including zero and values beyond the maximum
   function automatic window_type pick_window();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return window_type'(1);
      if (r == 2) return window_type'(MAX_WINDOW);
      if (r == 3) return window_type'($urandom_range(MAX_WINDOW + 1, WIN_TOP));
      if (r == 4) return window_type'(2);
      return window_type'($urandom_range(1, MAX_WINDOW));
   endfunction

   // record length, mostly short
   function automatic int pick_record_len();
      int r;
      r = $urandom_range(0, 9);
      if (r < 7) return $urandom_range(1, 20);
      if (r < 9) return $urandom_range(21, 70);
      return $urandom_range(71, 130);
   endfunction

   // offer one request and wait until it is taken
   task automatic send_request(input sample_type smp, input logic rst_rec, input bit no_gap);
      int gap;
      req_valid   <= 1'b1;
      req_sample  <= smp;
      req_restart <= rst_rec;
      do @(posedge clock); while (req_stall);
      requests_sent++;
      gap = no_gap ? 0 : pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // stop sending until every average has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // window length write, only while the block is idle
   task automatic write_window(input window_type len);
      csr_valid <= 1'b1;
      csr_data  <= len;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // shrink and grow the window inside one record so the sum drifts and wraps
   task automatic run_drift();
      int k;
      drain_results();
      write_window(window_type'(MAX_WINDOW));
      for (k = 0; k < MAX_WINDOW; k++) begin
         send_request(sample_type'($urandom_range(32000, 32767)), k == 0, 1'b0);
      end
      drain_results();
      write_window(window_type'(1));
      for (k = 0; k < MAX_WINDOW - 1; k++) begin
         send_request(sample_type'(-int'($urandom_range(32000, 32768))), 1'b0, 1'b0);
      end
      drain_results();
      write_window(window_type'(MAX_WINDOW));
      for (k = 0; k < MAX_WINDOW; k++) begin
         send_request(sample_type'($urandom_range(32000, 32767)), 1'b0, 1'b0);
      end
   endtask

   // result side stall pattern, with one long hold on request
   initial begin : rsp_side
      bit hold_done;
      bit stall_val;
      int run_len;
      int r;
      hold_done = 1'b0;
      @(posedge clock);
      forever begin
         if (hold_go && !hold_done) begin
            stall_val = 1'b1;
            run_len   = LONG_HOLD;
            hold_done = 1'b1;
         end else begin
            r = $urandom_range(0, 19);
            if (r < 11) begin
               stall_val = 1'b0;
               run_len   = $urandom_range(1, 6);
            end else if (r < 13) begin
               stall_val = 1'b0;
               run_len   = $urandom_range(50, 200);
            end else if (r < 19) begin
               stall_val = 1'b1;
               run_len   = $urandom_range(1, 4);
            end else begin
               stall_val = 1'b1;
               run_len   = $urandom_range(20, 60);
            end
         end
         rsp_stall <= stall_val;
         repeat (run_len) @(posedge clock);
      end
   end

   // run limit
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("moving_window_average_top test failed");
      $finish;
   end

   // stimulus and verdict
   initial begin : stimulus
      int  random_start;
      int  rec_len;
      int  k;
      bit  burst;
      bit  pressure_done;
      bit  drift_done;
      pressure_done = 1'b0;
      drift_done    = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // default window of 30, first record without a restart flag
      send_request(SMP_MAX, 1'b0, 1'b0);
      send_request(SMP_MAX, 1'b0, 1'b0);
      send_request(SMP_MIN, 1'b0, 1'b0);
      send_request('0, 1'b0, 1'b0);
      // negative sums truncate toward zero
      send_request(-sample_type'(1), 1'b1, 1'b0);
      send_request('0, 1'b0, 1'b0);
      send_request(-sample_type'(2), 1'b0, 1'b0);

      // zero length acts as one
      drain_results();
      write_window('0);
      send_request(SMP_MIN, 1'b1, 1'b0);
      send_request(SMP_MAX, 1'b0, 1'b0);

      // lengths above the maximum saturate
      drain_results();
      write_window(WIN_TOP);
      send_request(SMP_MAX, 1'b1, 1'b0);
      send_request(SMP_MIN, 1'b0, 1'b0);
      drain_results();
      write_window(window_type'(MAX_WINDOW + 1));
      send_request(sample_type'(5), 1'b1, 1'b0);

      // window shrunk inside a record, quotient clamps high
      drain_results();
      write_window(window_type'(2));
      send_request(SMP_MAX, 1'b1, 1'b0);
      send_request(SMP_MAX, 1'b0, 1'b0);
      send_request(SMP_MAX, 1'b0, 1'b0);
      drain_results();
      write_window(window_type'(1));
      send_request(SMP_MAX, 1'b0, 1'b0);
      send_request(SMP_MIN, 1'b0, 1'b0);

      // same going low
      drain_results();
      write_window(window_type'(2));
      send_request(SMP_MIN, 1'b1, 1'b0);
      send_request(SMP_MIN, 1'b0, 1'b0);
      drain_results();
      write_window(window_type'(1));
      send_request(SMP_MIN, 1'b0, 1'b0);

      drain_results();
      write_window(window_type'(MAX_WINDOW));
      send_request('0, 1'b1, 1'b0);

      // random records
      random_start = requests_sent;
      while (requests_sent - random_start < RANDOM_ITEMS) begin
         if (!pressure_done && requests_sent - random_start >= RANDOM_ITEMS / 3) begin
            // result side holds off while requests keep coming
            drain_results();
            hold_go <= 1'b1;
            for (k = 0; k < 32; k++) send_request(pick_sample(), k == 0, 1'b1);
            drain_results();
            pressure_done = 1'b1;
         end else if (!drift_done && requests_sent - random_start >= RANDOM_ITEMS / 2) begin
            run_drift();
            drift_done = 1'b1;
         end else begin
            if ($urandom_range(0, 2) == 0) begin
               drain_results();
               write_window(pick_window());
            end
            burst   = ($urandom_range(0, 3) == 0);
            rec_len = pick_record_len();
            for (k = 0; k < rec_len; k++) begin
               send_request(pick_sample(),
                            ((k == 0) && ($urandom_range(0, 7) != 0)) ||
                            ($urandom_range(0, 63) == 0),
                            burst);
            end
         end
      end

      drain_results();
      if (error_count == 0 && pending_count == 0) begin
         $display("moving_window_average_top test passed");
      end else begin
         $display("moving_window_average_top test failed");
      end
      $finish;
   end

endmodule
